>>> hw/rtl/itpbcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itpbcd_pkg;

   localparam int VALUE_IN_W = 64;
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 4;
   localparam int NIB_W      = 4;
   localparam int RADIX      = 10;

   typedef logic [NIB_W-1:0] nibble_type;

   localparam nibble_type NIB_TERM = 4'hF;
   localparam nibble_type NIB_SIGN = 4'hB;
   localparam nibble_type NIB_PAD  = 4'h0;

   // Shift-and-add-3 correction: a digit at or above half the radix gets
   // the amount that carries it into the next nibble on the following shift.
   localparam nibble_type DABBLE_LIMIT = nibble_type'(RADIX / 2);
   localparam nibble_type DABBLE_ADD   = nibble_type'((1 << (NIB_W - 1)) - RADIX / 2);

endpackage

`default_nettype wire

>>> hw/rtl/itpbcd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itpbcd_req_if
   import itpbcd_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [VALUE_IN_W-1:0] value;
   logic                  is_signed;

   modport source (output valid, output value, output is_signed, input ready);
   modport sink   (input valid, input value, input is_signed, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/itpbcd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itpbcd_rsp_if
   import itpbcd_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic [COUNT_W-1:0] byte_count;
   logic               last_byte;

   modport source (output valid, output out_byte, output byte_count, output last_byte,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_count, input last_byte,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/itpbcd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module itpbcd_queue #(
   parameter int WIDTH = 65
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/itpbcd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module itpbcd_front #(
   parameter int VALUE_WIDTH = 64
) (
   itpbcd_req_if.sink             req_ch,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [VALUE_WIDTH:0]   push_data
);

   logic [VALUE_WIDTH-1:0] raw;
   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag;

   // The negated most negative value wraps to itself, which read as
   // unsigned is exactly its magnitude.
   always_comb begin
      raw = req_ch.value[VALUE_WIDTH-1:0];
      neg = req_ch.is_signed && raw[VALUE_WIDTH-1];
      mag = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;
   assign push_data    = {neg, mag};

endmodule

`default_nettype wire

>>> hw/rtl/itpbcd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module itpbcd_back
   import itpbcd_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  logic [VALUE_WIDTH:0] pop_data,
   itpbcd_rsp_if.source         rsp_ch
);

   localparam int ND  = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BW  = ND * NIB_W;
   localparam int SW  = BW + 2 * NIB_W;
   localparam int BCW = $clog2(VALUE_WIDTH);
   localparam int NDW = $clog2(ND + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_NORM = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [SW-1:0]          stream_ff, stream_in;
   logic [BCW-1:0]         bit_cnt_ff, bit_cnt_in;
   logic [NDW-1:0]         ndig_ff, ndig_in;
   logic                   neg_ff, neg_in;
   logic                   par_ff, par_in;
   logic [COUNT_W-1:0]     nb_ff, nb_in;
   logic [COUNT_W-1:0]     left_ff, left_in;
   logic                   valid_ff, valid_in;
   logic [BYTE_W-1:0]      byte_ff, byte_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   last_ff, last_in;
   logic [BW-1:0]          adj;
   logic [NDW:0]           nseq;
   logic                   load;

   always_comb begin
      nibble_type dig;
      for (int i = 0; i < ND; i++) begin
         dig = stream_ff[2 * NIB_W + i * NIB_W +: NIB_W];
         adj[i * NIB_W +: NIB_W] = (dig >= DABBLE_LIMIT) ? (dig + DABBLE_ADD) : dig;
      end
   end

   assign load = !valid_ff || rsp_ch.ready;
   assign nseq = {1'b0, ndig_ff} + {{NDW{1'b0}}, neg_ff} + (NDW + 1)'(2);

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      stream_in  = stream_ff;
      bit_cnt_in = bit_cnt_ff;
      ndig_in    = ndig_ff;
      neg_in     = neg_ff;
      par_in     = par_ff;
      nb_in      = nb_ff;
      left_in    = left_ff;
      valid_in   = valid_ff && !rsp_ch.ready;
      byte_in    = byte_ff;
      count_in   = count_ff;
      last_in    = last_ff;
      pop_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               mag_in     = pop_data[VALUE_WIDTH-1:0];
               neg_in     = pop_data[VALUE_WIDTH];
               stream_in  = {{BW{1'b0}}, NIB_TERM, NIB_TERM};
               bit_cnt_in = BCW'(VALUE_WIDTH - 1);
               ndig_in    = NDW'(ND);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            stream_in  = {adj[BW-2:0], mag_ff[VALUE_WIDTH-1], stream_ff[2*NIB_W-1:0]};
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BCW'(1);
            if (bit_cnt_ff == '0) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (stream_ff[SW-1 -: NIB_W] == NIB_PAD && ndig_ff != NDW'(1)) begin
               stream_in = {stream_ff[SW-NIB_W-1:0], NIB_TERM};
               ndig_in   = ndig_ff - NDW'(1);
            end else begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (neg_ff) begin
               stream_in = {NIB_SIGN, stream_ff[SW-1:NIB_W]};
            end
            nb_in    = COUNT_W'(nseq >> 1);
            left_in  = COUNT_W'(nseq >> 1);
            par_in   = nseq[0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               valid_in  = 1'b1;
               count_in  = nb_ff;
               last_in   = (left_ff == COUNT_W'(1));
               if (left_ff == COUNT_W'(1) && !par_ff) begin
                  byte_in = {stream_ff[SW-1 -: NIB_W], NIB_PAD};
               end else begin
                  byte_in = stream_ff[SW-1 -: BYTE_W];
               end
               stream_in = {stream_ff[SW-BYTE_W-1:0], NIB_TERM, NIB_TERM};
               left_in   = left_ff - COUNT_W'(1);
               if (left_ff == COUNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      stream_ff  <= stream_in;
      bit_cnt_ff <= bit_cnt_in;
      ndig_ff    <= ndig_in;
      neg_ff     <= neg_in;
      par_ff     <= par_in;
      nb_ff      <= nb_in;
      left_ff    <= left_in;
      byte_ff    <= byte_in;
      count_ff   <= count_in;
      last_ff    <= last_in;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_byte   = byte_ff;
   assign rsp_ch.byte_count = count_ff;
   assign rsp_ch.last_byte  = last_ff;

   a_emit_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> left_ff != '0)
      else $error("Emit state entered with no bytes left.");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && load && left_ff == COUNT_W'(1))
      |=> (valid_ff && last_ff && state_ff == ST_IDLE))
      else $error("Final word of a number was not marked last.");

   a_normalized: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> (stream_ff[SW-1 -: NIB_W] != NIB_PAD || ndig_ff == NDW'(1)))
      else $error("Leading zero digit left after normalization.");

   a_count_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && valid_ff && left_ff != nb_ff) |-> count_ff == nb_ff)
      else $error("Byte count changed within a number.");

endmodule

`default_nettype wire

>>> hw/rtl/int_to_packed_bcd_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word
// req_ch    in         value[63:0], is_signed
// rsp_ch    out        out_byte[7:0], byte_count[3:0], last_byte
//
// A number leaves the queue, runs through the shift-and-add-3 loop over all
// VALUE_WIDTH bits, has its leading zero digits dropped in normalization,
// gets its sign and byte count, and is sent as 1 to 11 output words.
// Reset is synchronous and clears the queue and the sequencer. A two-entry
// queue buffers input words, and the output register holds a word until taken.

module int_to_packed_bcd_encoder
   import itpbcd_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   itpbcd_req_if.sink   req_ch,
   itpbcd_rsp_if.source rsp_ch
);

   logic                 push_valid;
   logic                 push_ready;
   logic [VALUE_WIDTH:0] push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   logic [VALUE_WIDTH:0] pop_data;

   itpbcd_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   itpbcd_queue #(
      .WIDTH (VALUE_WIDTH + 1)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   itpbcd_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

>>> test/itpbcd_checker.sv
`timescale 1ns / 1ps

module itpbcd_checker
   import itpbcd_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   itpbcd_req_if req_mon,
   itpbcd_rsp_if rsp_mon,
   output int    fail_count,
   output int    words_due
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [COUNT_W-1:0] byte_count;
      logic               last_byte;
   } bcd_word_t;

   bcd_word_t expected_words[$];

   // Builds the packed decimal byte run of one number and queues its words.
   task automatic queue_packed_bcd(input logic [VALUE_IN_W-1:0] raw, input logic as_signed);
      nibble_type        digits [0:19];
      nibble_type        stream [0:23];
      logic [VALUE_IN_W-1:0] mag;
      logic              neg;
      int                nd;
      int                ns;
      int                nbytes;
      bcd_word_t         w;
      nd = 0;
      ns = 0;
      neg = as_signed && raw[VALUE_IN_W-1];
      mag = neg ? (~raw + 1'b1) : raw;
      do begin
         digits[nd] = nibble_type'(mag % RADIX);
         mag = mag / RADIX;
         nd++;
      end while (mag != 0);
      if (neg) begin
         stream[ns] = NIB_SIGN;
         ns++;
      end
      for (int i = nd - 1; i >= 0; i--) begin
         stream[ns] = digits[i];
         ns++;
      end
      stream[ns] = NIB_TERM;
      ns++;
      if (ns % 2 != 0) begin
         stream[ns] = NIB_PAD;
         ns++;
      end
      nbytes = ns / 2;
      for (int k = 0; k < nbytes; k++) begin
         w.out_byte   = {stream[2*k], stream[2*k+1]};
         w.byte_count = COUNT_W'(nbytes);
         w.last_byte  = (k == nbytes - 1);
         expected_words.push_back(w);
      end
   endtask

   initial begin
      fail_count = 0;
      words_due  = 0;
   end

   always @(posedge clock) begin
      bcd_word_t want;
      bcd_word_t got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            queue_packed_bcd(req_mon.value, req_mon.is_signed);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.out_byte, rsp_mon.byte_count, rsp_mon.last_byte};
            if (expected_words.size() == 0) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("%0t: unexpected word byte=%02h count=%0d last=%0b",
                           $realtime, got.out_byte, got.byte_count, got.last_byte);
               end
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("%0t: expected byte=%02h count=%0d last=%0b, got byte=%02h count=%0d last=%0b",
                              $realtime, want.out_byte, want.byte_count, want.last_byte,
                              got.out_byte, got.byte_count, got.last_byte);
                  end
                  fail_count++;
               end
            end
         end
      end
      words_due = expected_words.size();
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import itpbcd_pkg::*;

   localparam int RANDOM_ITEMS = 180;
   localparam int HOLD_CYCLES  = 400;
   localparam int LIMIT_CYCLES = 400000;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_due;
   int   cycle_count;
   bit   calm;
   bit   hold_go;

   itpbcd_req_if req_ch ();
   itpbcd_rsp_if rsp_ch ();

   int_to_packed_bcd_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   itpbcd_checker encode_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Entered and left at a falling edge.
   task automatic offer_number(input logic [VALUE_IN_W-1:0] v, input logic s);
      if (!calm && $urandom_range(99) < 7) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.value     <= v;
      req_ch.is_signed <= s;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain_pause;
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (words_due != 0);
   endtask

   task automatic pick_number(output logic [VALUE_IN_W-1:0] v, output logic s);
      logic [VALUE_IN_W-1:0] p;
      p = VALUE_IN_W'(1);
      s = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, $urandom} >> $urandom_range(63);
         2: begin
            v = ~({$urandom, $urandom} >> $urandom_range(63, 1)) + 1'b1;
            s = 1'b1;
         end
         default: begin
            repeat ($urandom_range(19)) p = p * RADIX;
            v = p + VALUE_IN_W'($urandom_range(2)) - 1'b1;
         end
      endcase
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 7);
         end
      end
   end

   initial begin
      logic [VALUE_IN_W-1:0] v;
      logic                  s;
      calm             = 1'b0;
      hold_go          = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.value     = '0;
      req_ch.is_signed = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_number(64'd0, 1'b0);
      offer_number(64'd0, 1'b1);
      offer_number(64'd1, 1'b0);
      offer_number(64'd9, 1'b1);
      offer_number(64'd10, 1'b0);
      offer_number(64'd99, 1'b0);
      offer_number(64'd100, 1'b1);
      offer_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      offer_number(64'hFFFF_FFFF_FFFF_FF83, 1'b1);
      offer_number(64'hFFFF_FFFF_FFFF_FF83, 1'b0);
      offer_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      offer_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      offer_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      offer_number(64'h8000_0000_0000_0000, 1'b1);
      offer_number(64'h8000_0000_0000_0000, 1'b0);
      offer_number(64'd10000000000000000000, 1'b0);
      offer_number(64'd9999999999999999999, 1'b0);
      offer_number(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
      offer_number(64'h5555_5555_5555_5555, 1'b1);
      offer_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      drain_pause();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 60 && n < 100);
         if (n == 30) begin
            drain_pause();
         end
         if (n == 120) begin
            hold_go = 1'b1;
         end
         pick_number(v, s);
         offer_number(v, s);
      end
      calm = 1'b0;
      drain_pause();
      repeat (100) @(negedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
